>>> sv/geodetic_to_local_enu_top_defines.svh
// ----------------------------------------------------------------------------
// geodetic to local enu: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GEODETIC_TO_LOCAL_ENU_TOP_DEFINES_SVH
`define GEODETIC_TO_LOCAL_ENU_TOP_DEFINES_SVH

// same-cycle implication
`define G2E_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define G2E_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/g2e_pkg.sv
// ----------------------------------------------------------------------------
// g2e_pkg
// types, constants and elaboration-time table builders for the enu converter
// ----------------------------------------------------------------------------
package g2e_pkg;

   // register indexes
   localparam logic [1:0] REG_HOME_LON    = 2'd0;
   localparam logic [1:0] REG_HOME_LAT    = 2'd1;
   localparam logic [1:0] REG_HOME_HEIGHT = 2'd2;
   localparam logic [1:0] REG_HOME_VALID  = 2'd3;

   localparam longint ONE_Q60   = 64'sd1 <<< 60;
   localparam longint THREE_Q60 = 3 * ONE_Q60;

   // earth radius in mm
   localparam logic signed [34:0] EARTH_RADIUS_MM = 35'sd6371000000;

   // item passed from front to back
   typedef struct packed {
      logic signed [31:0] fix_longitude;
      logic signed [30:0] fix_latitude;
      logic signed [26:0] fix_height;
      logic signed [31:0] home_lon;
      logic signed [30:0] home_lat;
      logic signed [34:0] rad_fix;
      logic signed [34:0] rad_home;
      logic               home_valid;
   } g2e_item_type;

   // sine and cosine of both fix angles
   typedef struct packed {
      logic signed [63:0] sl;
      logic signed [63:0] cl;
      logic signed [63:0] sp;
      logic signed [63:0] cp;
   } g2e_trig_type;

   // delayed sideband of one item
   typedef struct packed {
      logic signed [26:0] height;
      logic               hv;
   } g2e_side_type;

   // radii of fix and home
   typedef struct packed {
      logic signed [34:0] rad_fix;
      logic signed [34:0] rad_home;
   } g2e_rad_type;

   // rotation factors cl*sp and sl*sp
   typedef struct packed {
      logic signed [63:0] u;
      logic signed [63:0] v;
   } g2e_uv_type;

   // v divided by the k-th odd number
   function automatic longint odd_div(longint v, int k);
      longint r;
      case (k)
         0:  r = v;
         1:  r = v / 3;
         2:  r = v / 5;
         3:  r = v / 7;
         4:  r = v / 9;
         5:  r = v / 11;
         6:  r = v / 13;
         7:  r = v / 15;
         8:  r = v / 17;
         9:  r = v / 19;
         10: r = v / 21;
         11: r = v / 23;
         12: r = v / 25;
         13: r = v / 27;
         14: r = v / 29;
         15: r = v / 31;
         16: r = v / 33;
         17: r = v / 35;
         18: r = v / 37;
         19: r = v / 39;
         20: r = v / 41;
         21: r = v / 43;
         22: r = v / 45;
         23: r = v / 47;
         24: r = v / 49;
         25: r = v / 51;
         26: r = v / 53;
         27: r = v / 55;
         28: r = v / 57;
         29: r = v / 59;
         default: r = 0;
      endcase
      return r;
   endfunction

   // atan(1/5) in q60, truncated series
   function automatic longint atan_recip5();
      longint sum;
      longint p;
      longint t;
      sum = 0;
      p = ONE_Q60 / 5;
      for (int k = 0; k < 30; k++) begin
         if (p != 0) begin
            t = odd_div(p, k);
            sum = (k % 2 == 1) ? sum - t : sum + t;
            p = p / 25;
         end
      end
      return sum;
   endfunction

   // atan(1/239) in q60, truncated series
   function automatic longint atan_recip239();
      longint sum;
      longint p;
      longint t;
      sum = 0;
      p = ONE_Q60 / 239;
      for (int k = 0; k < 30; k++) begin
         if (p != 0) begin
            t = odd_div(p, k);
            sum = (k % 2 == 1) ? sum - t : sum + t;
            p = p / 57121;
         end
      end
      return sum;
   endfunction

   localparam longint QUARTER_PI_Q60 = 4 * atan_recip5() - atan_recip239();
   localparam longint PI_Q60         = 4 * QUARTER_PI_Q60;
   localparam longint HALF_PI_Q60    = PI_Q60 / 2;
   localparam longint DEG7_TO_RAD    = ((PI_Q60 / 1800000000) <<< 10)
                                     + ((PI_Q60 % 1800000000) <<< 10) / 1800000000;

   // cordic arctangent of 2^-i in q60
   function automatic longint atan_q60(int i);
      longint sum;
      longint t;
      sum = 0;
      if (i == 0) begin
         sum = QUARTER_PI_Q60;
      end else begin
         for (int k = 0; k < 30; k++) begin
            if (i * (2 * k + 1) <= 60) begin
               t = odd_div(64'sd1 <<< (60 - i * (2 * k + 1)), k);
               sum = (k % 2 == 1) ? sum - t : sum + t;
            end
         end
      end
      return sum;
   endfunction

   // exact product shifted right, truncated toward zero
   function automatic longint mulshift_c(longint a, longint b, int s);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] p;
      logic [63:0]  r;
      logic         neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      p = {64'd0, ua} * {64'd0, ub};
      r = 64'(p >> s);
      r[63] = 1'b0;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // reciprocal of the cordic gain, newton iteration in q60
   function automatic longint cordic_inv_gain(int stages);
      longint prod;
      longint y;
      longint t;
      prod = ONE_Q60;
      for (int i = 0; i < stages; i++) begin
         if (2 * i < 63) prod = prod + (prod >>> (2 * i));
      end
      y = THREE_Q60 / 5;
      for (int it = 0; it < 8; it++) begin
         t = mulshift_c(y, y, 60);
         t = mulshift_c(prod, t, 60);
         y = mulshift_c(y, THREE_Q60 - t, 61);
      end
      return y;
   endfunction

endpackage

>>> sv/g2e_queue.sv
// ----------------------------------------------------------------------------
// g2e_queue
// small fifo between the accepting front and the arithmetic back
// ----------------------------------------------------------------------------
module g2e_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  g2e_pkg::g2e_item_type din,
   input  logic                  pop,
   output g2e_pkg::g2e_item_type dout,
   output logic                  full,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   g2e_pkg::g2e_item_type mem_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= din;
   end
endmodule

>>> sv/g2e_mul.sv
// ----------------------------------------------------------------------------
// g2e_mul
// signed 64x64 product shifted right, truncated toward zero, two stages
// ----------------------------------------------------------------------------
module g2e_mul #(
   parameter int SHIFT = 60
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] p
);
   logic [63:0]  ua, ub;
   logic [63:0]  pp0_ff, pp1_ff, pp2_ff, pp3_ff;
   logic         neg_ff;
   logic [127:0] full;
   logic [62:0]  mag;
   logic signed [63:0] p_ff, p_in;

   // magnitudes and 32x32 partial products
   assign ua = a[63] ? 64'(-a) : 64'(a);
   assign ub = b[63] ? 64'(-b) : 64'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff <= {32'd0, ua[31:0]}  * {32'd0, ub[31:0]};
         pp1_ff <= {32'd0, ua[31:0]}  * {32'd0, ub[63:32]};
         pp2_ff <= {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
         pp3_ff <= {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
         neg_ff <= a[63] ^ b[63];
      end
   end

   // sum, select and restore the sign
   always_comb begin
      full = {64'd0, pp0_ff} + ({64'd0, pp1_ff} << 32) + ({64'd0, pp2_ff} << 32)
           + ({64'd0, pp3_ff} << 64);
      mag  = full[SHIFT+62:SHIFT];
      p_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

>>> sv/g2e_sincos.sv
// ----------------------------------------------------------------------------
// g2e_sincos
// angle in 1e-7 degree to sine and cosine in q60 through a cordic pipeline
// ----------------------------------------------------------------------------
module g2e_sincos #(
   parameter int STAGES = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] angle,
   output logic signed [63:0] sin_q60,
   output logic signed [63:0] cos_q60
);
   localparam logic signed [63:0] INV_GAIN = 64'(g2e_pkg::cordic_inv_gain(STAGES));
   localparam logic signed [63:0] PI_Q      = 64'(g2e_pkg::PI_Q60);
   localparam logic signed [63:0] HALF_PI_Q = 64'(g2e_pkg::HALF_PI_Q60);
   localparam logic signed [63:0] K_DEG7    = 64'(g2e_pkg::DEG7_TO_RAD);

   logic signed [63:0] z_rad;
   logic signed [63:0] x_ff [0:STAGES];
   logic signed [63:0] y_ff [0:STAGES];
   logic signed [63:0] z_ff [0:STAGES];
   logic               flip_ff [0:STAGES];
   logic signed [63:0] z_fold_in;
   logic               flip_in;
   logic signed [63:0] sin_ff, cos_ff;

   // degrees to radians
   g2e_mul #(.SHIFT(10)) u_rad (
      .clock (clock),
      .en    (en),
      .a     ({{32{angle[31]}}, angle}),
      .b     (K_DEG7),
      .p     (z_rad)
   );

   // fold into the right half plane
   always_comb begin
      z_fold_in = z_rad;
      flip_in   = 1'b0;
      if (z_rad > HALF_PI_Q) begin
         z_fold_in = z_rad - PI_Q;
         flip_in   = 1'b1;
      end else if (z_rad < -HALF_PI_Q) begin
         z_fold_in = z_rad + PI_Q;
         flip_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= INV_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_fold_in;
         flip_ff[0] <= flip_in;
      end
   end

   // rotation stages
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [63:0] ATAN_I = 64'(g2e_pkg::atan_q60(i));
      logic signed [63:0] xs, ys;
      logic signed [63:0] x_in, y_in, z_in;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - ys;
            y_in = y_ff[i] + xs;
            z_in = z_ff[i] - ATAN_I;
         end else begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            z_in = z_ff[i] + ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // undo the fold
   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
         cos_ff <= flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      end
   end

   assign sin_q60 = sin_ff;
   assign cos_q60 = cos_ff;
endmodule

>>> sv/g2e_back.sv
// ----------------------------------------------------------------------------
// g2e_back
// arithmetic pipeline: trig, earth-centred coordinates, difference, rotation
// ----------------------------------------------------------------------------
module g2e_back #(
   parameter int STAGES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  g2e_pkg::g2e_item_type item,
   input  logic                  item_valid,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [34:0]    rsp_east_mm,
   output logic signed [34:0]    rsp_north_mm,
   output logic signed [26:0]    rsp_up_mm,
   output logic                  rsp_home_is_set
);
   localparam int T0  = STAGES + 4;
   localparam int LAT = T0 + 8;
   localparam logic signed [63:0] HALF_MM_Q20 = 64'sd1 <<< 19;

   logic en;
   logic [LAT:1] vld_ff, vld_in;

   g2e_pkg::g2e_side_type side_ff [1:LAT];
   g2e_pkg::g2e_rad_type  rad_ff  [1:T0+2];
   g2e_pkg::g2e_trig_type trig_ff [1:5];
   g2e_pkg::g2e_uv_type   uv_ff   [1:3];
   logic signed [63:0]    hsp_ff  [1:2];
   g2e_pkg::g2e_trig_type ftrig;

   logic signed [63:0] hsl, hcl, hsp, hcp;
   logic signed [63:0] t0, t1, u, v, ht0, ht1;
   logic signed [63:0] e0, e1, e2, g0, g1, g2;
   logic signed [63:0] dx_ff, dy_ff, dz_ff;
   logic signed [63:0] a1, a2, b1, b2, b3;
   logic signed [63:0] rad_fix64, rad_home64;
   logic signed [63:0] east_sum, north_sum;
   logic signed [63:0] east_rnd, north_rnd;
   logic signed [34:0] east_ff, east_in, north_ff, north_in;

   // pipeline advance and valid tracking
   assign en       = !(vld_ff[LAT] && rsp_stall);
   assign item_pop = en && item_valid;
   assign vld_in   = {vld_ff[LAT-1:1], item_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // sideband delay lines
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= '{height: item.fix_height, hv: item.home_valid};
         for (int k = 2; k <= LAT; k++) side_ff[k] <= side_ff[k-1];
         rad_ff[1] <= '{rad_fix: item.rad_fix, rad_home: item.rad_home};
         for (int k = 2; k <= T0 + 2; k++) rad_ff[k] <= rad_ff[k-1];
      end
   end

   // four trig lanes
   g2e_sincos #(.STAGES(STAGES)) u_fix_lon (
      .clock(clock), .en(en), .angle(item.fix_longitude),
      .sin_q60(ftrig.sl), .cos_q60(ftrig.cl));
   g2e_sincos #(.STAGES(STAGES)) u_fix_lat (
      .clock(clock), .en(en), .angle({item.fix_latitude[30], item.fix_latitude}),
      .sin_q60(ftrig.sp), .cos_q60(ftrig.cp));
   g2e_sincos #(.STAGES(STAGES)) u_home_lon (
      .clock(clock), .en(en), .angle(item.home_lon),
      .sin_q60(hsl), .cos_q60(hcl));
   g2e_sincos #(.STAGES(STAGES)) u_home_lat (
      .clock(clock), .en(en), .angle({item.home_lat[30], item.home_lat}),
      .sin_q60(hsp), .cos_q60(hcp));

   // trig delay lines toward the later products
   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff[1] <= ftrig;
         for (int k = 2; k <= 5; k++) trig_ff[k] <= trig_ff[k-1];
         hsp_ff[1] <= hsp;
         hsp_ff[2] <= hsp_ff[1];
         uv_ff[1] <= '{u: u, v: v};
         for (int k = 2; k <= 3; k++) uv_ff[k] <= uv_ff[k-1];
      end
   end

   // trig products
   g2e_mul #(.SHIFT(60)) u_m_t0  (.clock(clock), .en(en), .a(ftrig.cp), .b(ftrig.cl), .p(t0));
   g2e_mul #(.SHIFT(60)) u_m_t1  (.clock(clock), .en(en), .a(ftrig.cp), .b(ftrig.sl), .p(t1));
   g2e_mul #(.SHIFT(60)) u_m_u   (.clock(clock), .en(en), .a(ftrig.cl), .b(ftrig.sp), .p(u));
   g2e_mul #(.SHIFT(60)) u_m_v   (.clock(clock), .en(en), .a(ftrig.sl), .b(ftrig.sp), .p(v));
   g2e_mul #(.SHIFT(60)) u_m_ht0 (.clock(clock), .en(en), .a(hcp), .b(hcl), .p(ht0));
   g2e_mul #(.SHIFT(60)) u_m_ht1 (.clock(clock), .en(en), .a(hcp), .b(hsl), .p(ht1));

   // earth-centred coordinates in q20 mm
   assign rad_fix64  = 64'(rad_ff[T0+2].rad_fix);
   assign rad_home64 = 64'(rad_ff[T0+2].rad_home);

   g2e_mul #(.SHIFT(40)) u_m_e0 (.clock(clock), .en(en), .a(rad_fix64), .b(t0), .p(e0));
   g2e_mul #(.SHIFT(40)) u_m_e1 (.clock(clock), .en(en), .a(rad_fix64), .b(t1), .p(e1));
   g2e_mul #(.SHIFT(40)) u_m_e2 (.clock(clock), .en(en), .a(rad_fix64),
                                 .b(trig_ff[2].sp), .p(e2));
   g2e_mul #(.SHIFT(40)) u_m_g0 (.clock(clock), .en(en), .a(rad_home64), .b(ht0), .p(g0));
   g2e_mul #(.SHIFT(40)) u_m_g1 (.clock(clock), .en(en), .a(rad_home64), .b(ht1), .p(g1));
   g2e_mul #(.SHIFT(40)) u_m_g2 (.clock(clock), .en(en), .a(rad_home64),
                                 .b(hsp_ff[2]), .p(g2));

   // coordinate difference
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= e0 - g0;
         dy_ff <= e1 - g1;
         dz_ff <= e2 - g2;
      end
   end

   // rotation products
   g2e_mul #(.SHIFT(60)) u_m_a1 (.clock(clock), .en(en), .a(trig_ff[5].cl), .b(dy_ff), .p(a1));
   g2e_mul #(.SHIFT(60)) u_m_a2 (.clock(clock), .en(en), .a(trig_ff[5].sl), .b(dx_ff), .p(a2));
   g2e_mul #(.SHIFT(60)) u_m_b1 (.clock(clock), .en(en), .a(trig_ff[5].cp), .b(dz_ff), .p(b1));
   g2e_mul #(.SHIFT(60)) u_m_b2 (.clock(clock), .en(en), .a(uv_ff[3].u), .b(dx_ff), .p(b2));
   g2e_mul #(.SHIFT(60)) u_m_b3 (.clock(clock), .en(en), .a(uv_ff[3].v), .b(dy_ff), .p(b3));

   // round to mm, zero while home is unset
   always_comb begin
      east_sum  = a1 - a2;
      north_sum = b1 - b2 - b3;
      east_rnd  = (east_sum + HALF_MM_Q20) >>> 20;
      north_rnd = (north_sum + HALF_MM_Q20) >>> 20;
      east_in   = side_ff[LAT-1].hv ? east_rnd[34:0] : '0;
      north_in  = side_ff[LAT-1].hv ? north_rnd[34:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         east_ff  <= east_in;
         north_ff <= north_in;
      end
   end

   assign rsp_valid       = vld_ff[LAT];
   assign rsp_east_mm     = east_ff;
   assign rsp_north_mm    = north_ff;
   assign rsp_up_mm       = side_ff[LAT].height;
   assign rsp_home_is_set = side_ff[LAT].hv;
endmodule

>>> sv/geodetic_to_local_enu_top.sv
// ----------------------------------------------------------------------------
// geodetic_to_local_enu_top
// gps fix to east/north offsets from a home point on a spherical earth
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  fix longitude, latitude, height
//   rsp      out        rsp_valid / rsp_stall  east, north, up, home flag
//   csr      in         csr_wr_en              home lon, lat, height, valid
//
// one fix accepted per cycle while req_stall is low; each accepted fix passes
// through the queue, then through the cordic stage chain and the multipliers
// a four-entry queue keeps taking fixes while the result pipeline is stalled,
// until it is full; reset is synchronous and clears the queue, the pipeline
// valids and the home registers
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_top #(
   parameter int CORDIC_STAGES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_fix_longitude,
   input  logic signed [30:0] req_fix_latitude,
   input  logic signed [26:0] req_fix_height,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [34:0] rsp_east_mm,
   output logic signed [34:0] rsp_north_mm,
   output logic signed [26:0] rsp_up_mm,
   output logic               rsp_home_is_set,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   logic signed [31:0] home_lon_ff;
   logic signed [30:0] home_lat_ff;
   logic signed [26:0] home_height_ff;
   logic               home_valid_ff;

   g2e_pkg::g2e_item_type item_in, item_out;
   logic push, pop, q_full, q_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         home_lon_ff    <= '0;
         home_lat_ff    <= '0;
         home_height_ff <= '0;
         home_valid_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            g2e_pkg::REG_HOME_LON:    home_lon_ff    <= csr_wdata;
            g2e_pkg::REG_HOME_LAT:    home_lat_ff    <= csr_wdata[30:0];
            g2e_pkg::REG_HOME_HEIGHT: home_height_ff <= csr_wdata[26:0];
            g2e_pkg::REG_HOME_VALID:  home_valid_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // front: accept the fix, attach home and both radii
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      item_in.fix_longitude = req_fix_longitude;
      item_in.fix_latitude  = req_fix_latitude;
      item_in.fix_height    = req_fix_height;
      item_in.home_lon      = home_lon_ff;
      item_in.home_lat      = home_lat_ff;
      item_in.rad_fix       = g2e_pkg::EARTH_RADIUS_MM + 35'(req_fix_height);
      item_in.rad_home      = g2e_pkg::EARTH_RADIUS_MM + 35'(home_height_ff);
      item_in.home_valid    = home_valid_ff;
   end

   g2e_queue #(.DEPTH(4)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (item_in),
      .pop   (pop),
      .dout  (item_out),
      .full  (q_full),
      .empty (q_empty)
   );

   // back: arithmetic pipeline
   g2e_back #(.STAGES(CORDIC_STAGES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .item            (item_out),
      .item_valid      (!q_empty),
      .item_pop        (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_east_mm     (rsp_east_mm),
      .rsp_north_mm    (rsp_north_mm),
      .rsp_up_mm       (rsp_up_mm),
      .rsp_home_is_set (rsp_home_is_set)
   );
endmodule

>>> sv/g2e_checker.sv
// ----------------------------------------------------------------------------
// g2e_checker
// port-level checks for the enu converter, bound to the top level
// ----------------------------------------------------------------------------
`include "geodetic_to_local_enu_top_defines.svh"

module g2e_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [34:0] rsp_east_mm,
   input logic signed [34:0] rsp_north_mm,
   input logic signed [26:0] rsp_up_mm,
   input logic               rsp_home_is_set
);
   // a stalled result holds
   `G2E_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_east_mm) && $stable(rsp_north_mm) && $stable(rsp_up_mm) && $stable(rsp_home_is_set), "stalled result changed")

   // offsets are zero without a home point
   `G2E_ASSERT_IMP(a_no_home_zero, clock, reset, rsp_valid && !rsp_home_is_set, rsp_east_mm == 35'sd0 && rsp_north_mm == 35'sd0, "offset without home point")

   // reset empties queue and pipeline
   `G2E_ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && !req_stall, "not empty after reset")
endmodule

bind geodetic_to_local_enu_top g2e_checker u_g2e_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_east_mm     (rsp_east_mm),
   .rsp_north_mm    (rsp_north_mm),
   .rsp_up_mm       (rsp_up_mm),
   .rsp_home_is_set (rsp_home_is_set)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: geodetic to local enu converter
// drives gps fixes through the converter under random gaps and output stalls
// and several home positions; a bit-exact fixed-point cordic predictor checks
// east, north, up and the home flag of every result in order
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES  = 32;
   localparam int LATENCY = STAGES + 24;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_fix_longitude = '0;
   logic signed [30:0] req_fix_latitude = '0;
   logic signed [26:0] req_fix_height = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [34:0] rsp_east_mm;
   logic signed [34:0] rsp_north_mm;
   logic signed [26:0] rsp_up_mm;
   logic               rsp_home_is_set;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   bit                 calm = 1'b0;

   // expected offsets of one fix
   typedef struct {
      logic signed [34:0] east;
      logic signed [34:0] north;
      logic signed [26:0] up;
      logic               home_set;
   } enu_result_type;

   // home registers, fixed-point tables and the queue of pending offsets
   class enu_tracker;
      longint         home_lon, home_lat, home_h;
      bit             home_set;
      longint         atan_q[STAGES];
      longint         pi_q, rad_per_deg7, inv_gain;
      enu_result_type pending_enu[$];
      int             errors;

      function new();
         longint quarter, prod, y, t, sum;
         quarter = 4 * atan_inv(5) - atan_inv(239);
         pi_q = 4 * quarter;
         rad_per_deg7 = ((pi_q / 1800000000) << 10) + ((pi_q % 1800000000) << 10) / 1800000000;
         atan_q[0] = quarter;
         for (int i = 1; i < STAGES; i++) begin
            sum = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
               t = (64'sd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
               sum = (k % 2) ? sum - t : sum + t;
            end
            atan_q[i] = sum;
         end
         prod = 64'sd1 << 60;
         for (int i = 0; i < STAGES; i++)
            if (2 * i < 63) prod += prod >>> (2 * i);
         y = (3 * (64'sd1 << 60)) / 5;
         for (int n = 0; n < 8; n++) begin
            t = mul_trunc(prod, mul_trunc(y, y, 60), 60);
            y = mul_trunc(y, 3 * (64'sd1 << 60) - t, 61);
         end
         inv_gain = y;
      endfunction

      function longint atan_inv(longint n);
         longint sum, p, t;
         sum = 0;
         p = (64'sd1 << 60) / n;
         for (int k = 0; p != 0; k++) begin
            t = p / (2 * k + 1);
            sum = (k % 2) ? sum - t : sum + t;
            p = p / (n * n);
         end
         return sum;
      endfunction

      // exact product, shifted and truncated toward zero
      function longint mul_trunc(longint a, longint b, int s);
         logic signed [127:0] pa, pb, p;
         logic [127:0]        m;
         longint              r;
         pa = a;
         pb = b;
         p = pa * pb;
         m = (p < 0) ? -p : p;
         r = longint'(m >> s) & 64'h7FFF_FFFF_FFFF_FFFF;
         return (p < 0) ? -r : r;
      endfunction

      function void sin_cos(longint deg7, output longint s, output longint c);
         longint z, x, y, xs, ys;
         bit     flip;
         z = mul_trunc(deg7, rad_per_deg7, 10);
         x = inv_gain;
         y = 0;
         flip = 0;
         if (z > pi_q / 2) begin
            z -= pi_q;
            flip = 1;
         end else if (z < -(pi_q / 2)) begin
            z += pi_q;
            flip = 1;
         end
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_q[i];
            end else begin
               x += ys; y -= xs; z += atan_q[i];
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      // earth-centred position in q20 mm plus the angle terms
      function void ecef(longint lon, longint lat, longint h, output longint p[3],
                         output longint sl, output longint cl, output longint sp,
                         output longint cp);
         longint rad;
         rad = 64'sd6371000000 + h;
         sin_cos(lon, sl, cl);
         sin_cos(lat, sp, cp);
         p[0] = mul_trunc(rad, mul_trunc(cp, cl, 60), 40);
         p[1] = mul_trunc(rad, mul_trunc(cp, sl, 60), 40);
         p[2] = mul_trunc(rad, sp, 40);
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            g2e_pkg::REG_HOME_LON:    home_lon = longint'($signed(v));
            g2e_pkg::REG_HOME_LAT:    home_lat = longint'($signed(v[30:0]));
            g2e_pkg::REG_HOME_HEIGHT: home_h = longint'($signed(v[26:0]));
            g2e_pkg::REG_HOME_VALID:  home_set = v[0];
         endcase
      endfunction

      // accepted fix: work out its offsets
      function void note_fix(longint lon, longint lat, longint h);
         longint         f[3], g[3];
         longint         sl, cl, sp, cp, a, b, c, d;
         longint         east, north;
         enu_result_type r;
         east = 0;
         north = 0;
         ecef(lon, lat, h, f, sl, cl, sp, cp);
         if (home_set) begin
            ecef(home_lon, home_lat, home_h, g, a, b, c, d);
            east = (mul_trunc(cl, f[1] - g[1], 60) - mul_trunc(sl, f[0] - g[0], 60)
                    + (64'sd1 << 19)) >>> 20;
            north = (mul_trunc(cp, f[2] - g[2], 60)
                     - mul_trunc(mul_trunc(cl, sp, 60), f[0] - g[0], 60)
                     - mul_trunc(mul_trunc(sl, sp, 60), f[1] - g[1], 60)
                     + (64'sd1 << 19)) >>> 20;
         end
         r.east = east[34:0];
         r.north = north[34:0];
         r.up = h[26:0];
         r.home_set = home_set;
         pending_enu.push_back(r);
      endfunction

      function void check_result(logic signed [34:0] e, logic signed [34:0] n,
                                 logic signed [26:0] u, logic hs);
         enu_result_type x;
         if (pending_enu.size() == 0) begin
            $display("%0t: result with no fix pending: east %0d north %0d", $realtime, e, n);
            errors++;
            return;
         end
         x = pending_enu.pop_front();
         if (e !== x.east) begin
            $display("%0t: east expected %0d actual %0d", $realtime, x.east, e);
            errors++;
         end
         if (n !== x.north) begin
            $display("%0t: north expected %0d actual %0d", $realtime, x.north, n);
            errors++;
         end
         if (u !== x.up) begin
            $display("%0t: up expected %0d actual %0d", $realtime, x.up, u);
            errors++;
         end
         if (hs !== x.home_set) begin
            $display("%0t: home flag expected %0b actual %0b", $realtime, x.home_set, hs);
            errors++;
         end
      endfunction
   endclass

   enu_tracker trk = new();

   geodetic_to_local_enu_top #(.CORDIC_STAGES(STAGES)) i_dut (.*);

   always #10 clock = ~clock;

   // output stalls
   always @(posedge clock)
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < 15);

   // result checking
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         trk.check_result(rsp_east_mm, rsp_north_mm, rsp_up_mm, rsp_home_is_set);

   // send one fix, with an occasional gap first
   task automatic send_fix(longint lon, longint lat, longint h);
      if (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_fix_longitude <= lon[31:0];
      req_fix_latitude <= lat[30:0];
      req_fix_height <= h[26:0];
      do @(posedge clock); while (req_stall);
      trk.note_fix(longint'(req_fix_longitude), longint'(req_fix_latitude),
                   longint'(req_fix_height));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (trk.pending_enu.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, longint v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[31:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trk.set_reg(idx, v[31:0]);
   endtask

   task automatic set_home(longint lon, longint lat, longint h, bit ok);
      wait_drained();
      write_reg(g2e_pkg::REG_HOME_LON, lon);
      write_reg(g2e_pkg::REG_HOME_LAT, lat);
      write_reg(g2e_pkg::REG_HOME_HEIGHT, h);
      write_reg(g2e_pkg::REG_HOME_VALID, ok);
   endtask

   // fixes near home most often, some anywhere on the globe, some raw bit patterns
   task automatic send_random(int count, int calm_from, int calm_to);
      longint lon, lat, h;
      int     pick;
      for (int i = 0; i < count; i++) begin
         calm = (i >= calm_from && i < calm_to);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            lon = trk.home_lon + longint'($urandom_range(0, 400000)) - 200000;
            lat = trk.home_lat + longint'($urandom_range(0, 400000)) - 200000;
            h = longint'($urandom_range(0, 51000000)) - 1000000;
         end else if (pick < 85) begin
            lon = longint'($urandom_range(0, 3600000000)) - 1800000000;
            lat = longint'($urandom_range(0, 1800000000)) - 900000000;
            h = longint'($urandom_range(0, 51000000)) - 1000000;
         end else begin
            lon = longint'($signed($urandom()));
            lat = longint'($signed($urandom()));
            h = longint'($signed($urandom()));
         end
         send_fix(lon, lat, h);
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // home not yet set
      send_random(20, 0, 0);

      // home at the positive extremes, directed corner fixes
      set_home(1800000000, 900000000, 50000000, 1'b1);
      send_fix(0, 0, 0);
      send_fix(1800000000, 900000000, 50000000);
      send_fix(-1800000000, -900000000, -1000000);
      send_fix(-2147483648, -1073741824, -67108864);
      send_fix(2147483647, 1073741823, 67108863);
      send_fix(900000000, 900000001, 0);
      send_fix(900000001, -900000001, 12345);
      send_fix(-900000000, -900000000, -1);
      send_fix(-900000001, 899999999, 1);
      send_fix(1799999999, 1, 49999999);
      send_fix(1, -1, -999999);
      send_fix(1800000000, 899999900, 49999000);
      send_fix(-1, 0, 0);
      send_fix(1073741824, 536870912, 33554432);
      send_fix(-1073741825, -536870913, -33554433);
      send_fix(1800000001, 900000000, 50000000);
      send_random(90, 0, 0);

      // negative extremes, with a stretch without gaps or stalls
      set_home(-1800000000, -900000000, -1000000, 1'b1);
      send_random(100, 20, 70);

      // full field extremes
      set_home(-2147483648, -1073741824, 67108863, 1'b1);
      send_random(80, 0, 0);

      // random home within range
      set_home(longint'($urandom_range(0, 3600000000)) - 1800000000,
               longint'($urandom_range(0, 1800000000)) - 900000000,
               longint'($urandom_range(0, 51000000)) - 1000000, 1'b1);
      send_random(100, 0, 0);

      // home written but flagged invalid
      set_home(2147483647, 1073741823, -67108864, 1'b0);
      send_random(60, 0, 0);

      wait_drained();
      if (trk.errors == 0 && trk.pending_enu.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/g2e_pkg.sv
sv/g2e_queue.sv
sv/g2e_mul.sv
sv/g2e_sincos.sv
sv/g2e_back.sv
sv/geodetic_to_local_enu_top.sv
sv/g2e_checker.sv
verif/tb.sv
